[hdl/hfr_pkg.sv]
// hfr_pkg: shared types and constants for the header frame receiver.
// No dependencies.
package hfr_pkg;

    localparam int unsigned ByteWidth     = 8;
    localparam int unsigned WordWidth     = 32;
    localparam int unsigned PayloadLen    = 14;
    localparam int unsigned CountWidth    = 4;
    localparam int unsigned CfgIndexWidth = 2;

    localparam logic [ByteWidth-1:0] FirstHeaderReset  = 8'hAA;
    localparam logic [ByteWidth-1:0] SecondHeaderReset = 8'hDD;

    localparam logic [CfgIndexWidth-1:0] CfgFirstHeader  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CfgSecondHeader = 2'd1;

    localparam logic [CountWidth-1:0] LastPayloadIdx = CountWidth'(PayloadLen - 1);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SYNC2   = 2'd1,
        PH_COLLECT = 2'd2,
        PH_PUBLISH = 2'd3
    } phase_t;

    typedef struct packed {
        logic [ByteWidth-1:0] first_header;
        logic [ByteWidth-1:0] second_header;
    } sync_cfg_t;

    typedef struct packed {
        logic [ByteWidth-1:0] command;
        logic [ByteWidth-1:0] frame_id;
        logic [WordWidth-1:0] z_bits;
        logic [WordWidth-1:0] x_bits;
        logic [WordWidth-1:0] y_bits;
    } frame_t;

endpackage

[hdl/hfr_cfg_regs.sv]
// hfr_cfg_regs: sync byte configuration registers.
// Depends on hfr_pkg.
module hfr_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_fire,
    input  logic [hfr_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [hfr_pkg::ByteWidth-1:0]       cfg_data,
    output hfr_pkg::sync_cfg_t                  sync_cfg
);
    import hfr_pkg::*;

    sync_cfg_t cfg_reg;
    sync_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_fire) begin
            case (cfg_index)
                CfgFirstHeader:  cfg_next.first_header  = cfg_data;
                CfgSecondHeader: cfg_next.second_header = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_header  <= FirstHeaderReset;
            cfg_reg.second_header <= SecondHeaderReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign sync_cfg = cfg_reg;

endmodule

[hdl/hfr_parser.sv]
// hfr_parser: sync hunt state machine and payload shift store.
// Depends on hfr_pkg.
module hfr_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_fire,
    input  logic [hfr_pkg::ByteWidth-1:0]   rx_byte,
    input  hfr_pkg::sync_cfg_t              sync_cfg,
    output logic                            publish,
    output hfr_pkg::frame_t                 frame
);
    import hfr_pkg::*;

    phase_t                state_reg;
    phase_t                state_next;
    logic [CountWidth-1:0] count_reg;
    logic [CountWidth-1:0] count_next;
    logic [ByteWidth-1:0]  store_reg [PayloadLen];
    logic                  store_shift;
    logic                  count_clear;

    always_comb begin
        state_next = state_reg;
        if (in_fire) begin
            case (state_reg)
                PH_HUNT: begin
                    if (rx_byte == sync_cfg.first_header) state_next = PH_SYNC2;
                end
                PH_SYNC2: begin
                    if (rx_byte == sync_cfg.second_header) begin
                        state_next = PH_COLLECT;
                    end else if (rx_byte == sync_cfg.first_header) begin
                        state_next = PH_SYNC2;
                    end else begin
                        state_next = PH_HUNT;
                    end
                end
                PH_COLLECT: begin
                    if (count_reg == LastPayloadIdx) state_next = PH_PUBLISH;
                end
                PH_PUBLISH: state_next = PH_HUNT;
                default:    state_next = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        store_shift = 1'b0;
        publish     = 1'b0;
        count_clear = 1'b0;
        case (state_reg)
            PH_HUNT:    count_clear = in_fire && (rx_byte == sync_cfg.first_header);
            PH_SYNC2:   count_clear = 1'b0;
            PH_COLLECT: store_shift = in_fire;
            PH_PUBLISH: publish     = in_fire;
            default:    publish     = 1'b0;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (count_clear) begin
            count_next = '0;
        end else if (store_shift) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_HUNT;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // oldest byte ends up in entry 0 after a full payload
    always_ff @(posedge aclk) begin
        if (store_shift) begin
            for (int i = 0; i < PayloadLen - 1; i++) begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[PayloadLen-1] <= rx_byte;
        end
    end

    assign frame.command  = store_reg[0];
    assign frame.frame_id = store_reg[1];
    assign frame.z_bits   = {store_reg[5], store_reg[4], store_reg[3], store_reg[2]};
    assign frame.x_bits   = {store_reg[9], store_reg[8], store_reg[7], store_reg[6]};
    assign frame.y_bits   = {store_reg[13], store_reg[12], store_reg[11], store_reg[10]};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == PH_COLLECT |-> count_reg <= LastPayloadIdx)
        else $error("payload count overran");

    a_last_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && state_reg == PH_COLLECT && count_reg == LastPayloadIdx
        |=> state_reg == PH_PUBLISH)
        else $error("full payload did not lead to publish");

    a_publish_ret: assert property (@(posedge aclk) disable iff (!aresetn)
        publish |=> state_reg == PH_HUNT && count_reg == CountWidth'(PayloadLen))
        else $error("publish did not return to hunt with a full count");

endmodule

[hdl/hfr_out_stage.sv]
// hfr_out_stage: result register holding one decoded frame until taken.
// Depends on hfr_pkg.
module hfr_out_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  hfr_pkg::frame_t frame_in,
    input  logic            m_ready,
    output logic            m_valid,
    output logic            slot_free,
    output hfr_pkg::frame_t frame_out
);
    import hfr_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    frame_t frame_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= frame_in;
        end
    end

    assign slot_free = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign frame_out = frame_reg;

endmodule

[hdl/header_frame_receiver.sv]
// header_frame_receiver: two-byte sync serial frame parser, top level.
// Depends on hfr_pkg, hfr_cfg_regs, hfr_parser, hfr_out_stage.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | s_rx_byte
//  m_       | out       | m_command, m_frame_id, m_z_bits, m_x_bits, m_y_bits
//  cfg_     | in        | cfg_index, cfg_data (0 first_header, 1 second_header)
//
// One byte per cycle while s_ready is high; every byte is a single clocked state update.
// A frame appears on m_ in the cycle after the byte following its 14th payload byte is taken.
// Reset restores sync values 0xAA/0xDD and returns to hunting; no clearing pass.
// s_ready drops only while a frame waits in the result register and m_ready is low.
// cfg_ready is always high.
module header_frame_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [hfr_pkg::ByteWidth-1:0]       s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [hfr_pkg::ByteWidth-1:0]       m_command,
    output logic [hfr_pkg::ByteWidth-1:0]       m_frame_id,
    output logic [hfr_pkg::WordWidth-1:0]       m_z_bits,
    output logic [hfr_pkg::WordWidth-1:0]       m_x_bits,
    output logic [hfr_pkg::WordWidth-1:0]       m_y_bits,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hfr_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [hfr_pkg::ByteWidth-1:0]       cfg_data
);
    import hfr_pkg::*;

    sync_cfg_t sync_cfg;
    frame_t    frame;
    frame_t    frame_out;
    logic      publish;
    logic      slot_free;
    logic      in_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = slot_free;
    assign in_fire   = s_valid && slot_free;

    hfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sync_cfg  (sync_cfg)
    );

    hfr_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .rx_byte  (s_rx_byte),
        .sync_cfg (sync_cfg),
        .publish  (publish),
        .frame    (frame)
    );

    hfr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (publish),
        .frame_in  (frame),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .slot_free (slot_free),
        .frame_out (frame_out)
    );

    assign m_command  = frame_out.command;
    assign m_frame_id = frame_out.frame_id;
    assign m_z_bits   = frame_out.z_bits;
    assign m_x_bits   = frame_out.x_bits;
    assign m_y_bits   = frame_out.y_bits;

endmodule

[tb/tb.sv]
// tb: self-checking bench for header_frame_receiver, byte stream in, decoded frames out.
// Needs hfr_pkg and the header_frame_receiver RTL; a queue-fed driver and a clocked
// monitor, with sync values swept through several settings.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hfr_pkg::*;

    localparam logic [CfgIndexWidth-1:0] CfgSpareLo = 2'd2;
    localparam logic [CfgIndexWidth-1:0] CfgSpareHi = 2'd3;
    localparam int unsigned CycleLimit = 500000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [ByteWidth-1:0]     s_rx_byte = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [ByteWidth-1:0]     m_command;
    logic [ByteWidth-1:0]     m_frame_id;
    logic [WordWidth-1:0]     m_z_bits;
    logic [WordWidth-1:0]     m_x_bits;
    logic [WordWidth-1:0]     m_y_bits;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [ByteWidth-1:0]     cfg_data = '0;

    header_frame_receiver DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_command  (m_command),
        .m_frame_id (m_frame_id),
        .m_z_bits   (m_z_bits),
        .m_x_bits   (m_x_bits),
        .m_y_bits   (m_y_bits),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 aclk = ~aclk;

    // parser shadow state
    logic [ByteWidth-1:0]  sync_first = FirstHeaderReset;
    logic [ByteWidth-1:0]  sync_second = SecondHeaderReset;
    phase_t                rx_phase = PH_HUNT;
    logic [CountWidth-1:0] rx_count = '0;
    logic [ByteWidth-1:0]  rx_store [PayloadLen];

    logic [ByteWidth-1:0] rx_bytes_pending [$];
    frame_t               frames_due [$];

    int unsigned fault_count = 0;
    int unsigned bytes_in = 0;
    int unsigned frames_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned header_settings = 1;
    int unsigned cyc = 0;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    logic        long_hold_done = 1'b0;
    logic [1:0]  stall_mode = 2'd0;

    task automatic parse_byte(input logic [ByteWidth-1:0] b);
        frame_t f;
        case (rx_phase)
            PH_HUNT: begin
                if (b == sync_first) begin
                    rx_phase = PH_SYNC2;
                    rx_count = '0;
                end
            end
            PH_SYNC2: begin
                if (b == sync_second) rx_phase = PH_COLLECT;
                else if (b != sync_first) rx_phase = PH_HUNT;
            end
            PH_COLLECT: begin
                if (rx_count < PayloadLen) rx_store[rx_count] = b;
                rx_count = rx_count + 1'b1;
                if (rx_count >= PayloadLen) rx_phase = PH_PUBLISH;
            end
            default: begin
                f.command  = rx_store[0];
                f.frame_id = rx_store[1];
                f.z_bits   = {rx_store[5], rx_store[4], rx_store[3], rx_store[2]};
                f.x_bits   = {rx_store[9], rx_store[8], rx_store[7], rx_store[6]};
                f.y_bits   = {rx_store[13], rx_store[12], rx_store[11], rx_store[10]};
                frames_due.push_back(f);
                rx_phase = PH_HUNT;
            end
        endcase
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
                bytes_in++;
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (rx_bytes_pending.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_rx_byte <= rx_bytes_pending.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver: randomly chosen stall pattern, plus long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!long_hold_done && frames_seen >= 5) begin
            long_hold_done <= 1'b1;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4999) == 0) begin
            hold_left <= $urandom_range(100, 300);
            m_ready <= 1'b0;
        end else begin
            if (cyc[6:0] == 0) stall_mode <= 2'($urandom_range(0, 2));
            case (stall_mode)
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic void check_field(string tag, logic [WordWidth-1:0] want,
                                        logic [WordWidth-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, tag, want, got);
            fault_count++;
        end
    endfunction

    frame_t frame_want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            frames_seen++;
            if (frames_due.size() == 0) begin
                $display("%0t: unexpected frame expected none got cmd %h id %h z %h x %h y %h",
                         $time, m_command, m_frame_id, m_z_bits, m_x_bits, m_y_bits);
                fault_count++;
            end else begin
                frame_want = frames_due.pop_front();
                check_field("command", WordWidth'(frame_want.command), WordWidth'(m_command));
                check_field("frame_id", WordWidth'(frame_want.frame_id),
                            WordWidth'(m_frame_id));
                check_field("z_bits", frame_want.z_bits, m_z_bits);
                check_field("x_bits", frame_want.x_bits, m_x_bits);
                check_field("y_bits", frame_want.y_bits, m_y_bits);
            end
        end
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CycleLimit) begin
            $display("%0t: timeout with %0d frames outstanding", $time, frames_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [ByteWidth-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        if (idx == CfgFirstHeader) sync_first = val;
        else if (idx == CfgSecondHeader) sync_second = val;
        reg_writes++;
    endtask

    // sender pause: nothing goes out until every frame has come back
    task automatic wait_idle();
        while (rx_bytes_pending.size() != 0 || s_valid || frames_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic gen_traffic(input int unsigned n);
        int unsigned made;
        int unsigned pick;
        int unsigned k;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                k = $urandom_range(0, 2);
                repeat (k) rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
                rx_bytes_pending.push_back(sync_first);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) rx_bytes_pending.push_back(sync_first);
                rx_bytes_pending.push_back(sync_second);
                for (int i = 0; i < PayloadLen; i++) begin
                    case ($urandom_range(0, 15))
                        0: rx_bytes_pending.push_back(sync_first);
                        1: rx_bytes_pending.push_back(sync_second);
                        default: rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
                made += 17 + k;
            end else if (pick < 90) begin
                rx_bytes_pending.push_back(sync_first);
                rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
                made += 2;
            end else begin
                k = $urandom_range(1, 8);
                repeat (k) rx_bytes_pending.push_back(8'($urandom_range(0, 255)));
                made += k;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // broken sync, repeated first sync byte, sync values and extremes in payload
        rx_bytes_pending = '{FirstHeaderReset, 8'h55, 8'h13, FirstHeaderReset,
                             FirstHeaderReset, SecondHeaderReset,
                             8'h00, 8'hFF, FirstHeaderReset, SecondHeaderReset, 8'h01,
                             8'h80, 8'h7F, 8'hFE, 8'h55, 8'h33, 8'h0F, 8'hF0, 8'hC3, 8'h3C,
                             8'hFF};
        wait_idle();
        gen_traffic(180);
        wait_idle();

        write_reg(CfgFirstHeader, 8'h00);
        write_reg(CfgSecondHeader, 8'hFF);
        header_settings++;
        gen_traffic(200);
        wait_idle();

        // spare indices must leave the sync values alone
        write_reg(CfgSpareLo, 8'($urandom_range(0, 255)));
        write_reg(CfgSpareHi, 8'($urandom_range(0, 255)));
        gen_traffic(150);
        wait_idle();

        write_reg(CfgFirstHeader, 8'h5A);
        write_reg(CfgSecondHeader, 8'h5A);
        header_settings++;
        gen_traffic(200);
        wait_idle();

        write_reg(CfgFirstHeader, 8'hFF);
        write_reg(CfgSecondHeader, 8'h00);
        header_settings++;
        gen_traffic(200);
        wait_idle();

        repeat (2) begin
            write_reg(CfgFirstHeader, 8'($urandom_range(0, 255)));
            write_reg(CfgSecondHeader, 8'($urandom_range(0, 255)));
            header_settings++;
            gen_traffic(150);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        $display("covered %0d bytes and %0d frames over %0d sync settings, %0d register writes",
                 bytes_in, frames_seen, header_settings, reg_writes);
        if (fault_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
